// ----- design/gmti_pkg.sv -----
// ----------------------------------------------------------------------------
// gmti_pkg
// Shared types and constants of the grid mesh triangle indexer.
// ----------------------------------------------------------------------------
package gmti_pkg;

	localparam int CFG_W      = 8;
	localparam int HEIGHT_W   = 16;
	localparam int TOTAL_W    = 17;
	localparam int COUNT_W    = 19;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam int FIFO_DEPTH = 4;

	localparam logic signed [HEIGHT_W-1:0] HEIGHT_MIN = -16'sd16384;
	localparam logic signed [HEIGHT_W-1:0] HEIGHT_MAX = 16'sd16384;

	localparam logic [CFG_W-1:0] COLS_RESET = 8'd2;
	localparam logic [CFG_W-1:0] ROWS_RESET = 8'd2;

	typedef enum logic {
		REG_GRID_COLS = 1'b0,
		REG_GRID_ROWS = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [CFG_W-1:0] cols;
		logic [CFG_W-1:0] rows;
	} cfg_t;

	// classification of one vertex, handed from front to back
	typedef struct packed {
		logic tri_a;
		logic tri_b;
		logic diag_clk;
		logic done;
		logic end_present;
	} ctl_t;

endpackage

// ----- design/gmti_if.sv -----
// ----------------------------------------------------------------------------
// gmti_if
// Valid/ready channels for vertex heights and triangle results.
// ----------------------------------------------------------------------------
interface gmti_vertex_if;
	import gmti_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [HEIGHT_W-1:0] vertex_height;

	modport source (output valid, output vertex_height, input ready);
	modport sink   (input valid, input vertex_height, output ready);
endinterface

interface gmti_result_if #(
	parameter int INDEX_BITS = 16
);
	import gmti_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [INDEX_BITS-1:0] first_index;
	logic [INDEX_BITS-1:0] second_index;
	logic [INDEX_BITS-1:0] third_index;
	logic                  triangle_present;
	logic                  run_last;
	logic                  grid_done;
	logic [COUNT_W-1:0]    index_count;

	modport source (
		output valid, output first_index, output second_index, output third_index,
		output triangle_present, output run_last, output grid_done, output index_count,
		input ready
	);
	modport sink (
		input valid, input first_index, input second_index, input third_index,
		input triangle_present, input run_last, input grid_done, input index_count,
		output ready
	);
endinterface

// ----- design/gmti_regs.sv -----
// ----------------------------------------------------------------------------
// gmti_regs
// APB register file holding the grid size.
// ----------------------------------------------------------------------------
module gmti_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [gmti_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [gmti_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [gmti_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready,
	output gmti_pkg::cfg_t                      cfg
);
	import gmti_pkg::*;

	reg_idx_t idx;
	logic     wr;
	cfg_t     cfg_q;

	assign idx    = reg_idx_t'(paddr[2]);
	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cols <= COLS_RESET;
			cfg_q.rows <= ROWS_RESET;
		end else if (wr) begin
			unique case (idx)
				REG_GRID_COLS: cfg_q.cols <= pwdata[CFG_W-1:0];
				REG_GRID_ROWS: cfg_q.rows <= pwdata[CFG_W-1:0];
				default:       cfg_q      <= cfg_q;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_GRID_COLS: prdata = APB_DATA_W'(cfg_q.cols);
			REG_GRID_ROWS: prdata = APB_DATA_W'(cfg_q.rows);
			default:       prdata = '0;
		endcase
	end

endmodule

// ----- design/gmti_front.sv -----
// ----------------------------------------------------------------------------
// gmti_front
// Tracks the grid position, keeps the previous column's validity line and
// classifies each vertex into the triangles it closes.
// ----------------------------------------------------------------------------
module gmti_front #(
	parameter int MAX_ROWS   = 255,
	parameter int INDEX_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  gmti_pkg::cfg_t                   cfg,
	gmti_vertex_if.sink                      vtx,
	input  logic                             full,
	output logic                             push,
	output gmti_pkg::ctl_t                   ctl,
	output logic [gmti_pkg::COUNT_W-1:0]     count,
	output logic [INDEX_BITS-1:0]            yi,
	output logic [INDEX_BITS-1:0]            stride
);
	import gmti_pkg::*;

	localparam int ROW_W  = $clog2(MAX_ROWS + 1);
	localparam int PROD_W = CFG_W + ROW_W + 1;
	localparam int FULL_W = (PROD_W > INDEX_BITS) ? PROD_W : INDEX_BITS;

	logic                line_mem [MAX_ROWS+1];
	logic                line_rd_q;
	logic [CFG_W-1:0]    col_q;
	logic [ROW_W-1:0]    row_q;
	logic                diag_q;
	logic                below_q;
	logic [TOTAL_W-1:0]  total_q;

	logic                accept;
	logic [CFG_W-1:0]    cols;
	logic [CFG_W-1:0]    rows_nz;
	logic [ROW_W-1:0]    rows;
	logic                cur;
	logic                inner;
	logic [CFG_W-1:0]    i_m1;
	logic [ROW_W-1:0]    j_m1;
	logic [ROW_W:0]      stride_full;
	logic [FULL_W-1:0]   yi_full;
	logic                dir;
	logic                dclk;
	logic                tri_a;
	logic                tri_b;
	logic                final_v;
	logic                wrap;
	logic [TOTAL_W-1:0]  total_sum;
	logic [TOTAL_W-1:0]  total_fin;
	logic [ROW_W-1:0]    row_next;

	assign vtx.ready = !full;
	assign accept    = vtx.valid && !full;

	assign cols    = (cfg.cols == '0) ? CFG_W'(1) : cfg.cols;
	assign rows_nz = (cfg.rows == '0) ? CFG_W'(1) : cfg.rows;
	assign rows    = (int'(rows_nz) > MAX_ROWS) ? ROW_W'(MAX_ROWS) : ROW_W'(rows_nz);

	assign cur = (vtx.vertex_height >= HEIGHT_MIN) && (vtx.vertex_height <= HEIGHT_MAX);

	assign inner       = (col_q != '0) && (row_q != '0);
	assign i_m1        = col_q - CFG_W'(1);
	assign j_m1        = row_q - ROW_W'(1);
	assign stride_full = (ROW_W+1)'(rows) + (ROW_W+1)'(1);
	assign yi_full     = FULL_W'(i_m1) * FULL_W'(stride_full) + FULL_W'(j_m1);
	assign dir         = i_m1[0];
	assign dclk        = j_m1[0] ? dir : !dir;

	assign tri_a = inner && diag_q && line_rd_q && (dclk ? below_q : cur);
	assign tri_b = inner && cur && below_q && (dclk ? line_rd_q : diag_q);

	assign wrap    = (row_q >= rows);
	assign final_v = (col_q >= cols) && wrap;

	assign total_sum = total_q + TOTAL_W'(tri_a) + TOTAL_W'(tri_b);
	assign total_fin = (total_sum == '0) ? TOTAL_W'(1) : total_sum;

	assign push            = accept && (tri_a || tri_b || final_v);
	assign ctl.tri_a       = tri_a;
	assign ctl.tri_b       = tri_b;
	assign ctl.diag_clk    = dclk;
	assign ctl.done        = final_v;
	assign ctl.end_present = (total_q == '0);
	assign count           = COUNT_W'({total_fin, 1'b0}) + COUNT_W'(total_fin);
	assign yi              = INDEX_BITS'(yi_full);
	assign stride          = INDEX_BITS'(stride_full);

	assign row_next = !accept ? row_q : (wrap ? '0 : row_q + ROW_W'(1));

	always_ff @(posedge clk) begin
		if (accept) begin
			line_mem[row_q] <= cur;
		end
		line_rd_q <= line_mem[row_next];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			diag_q  <= 1'b0;
			below_q <= 1'b0;
			total_q <= '0;
		end else if (accept) begin
			row_q   <= row_next;
			diag_q  <= wrap ? 1'b0 : line_rd_q;
			below_q <= wrap ? 1'b0 : cur;
			total_q <= final_v ? '0 : total_sum;
			priority if (final_v) begin
				col_q <= '0;
			end else if (wrap) begin
				col_q <= col_q + CFG_W'(1);
			end
		end
	end

endmodule

// ----- design/gmti_fifo.sv -----
// ----------------------------------------------------------------------------
// gmti_fifo
// Short queue between the classifying front and the emitting back.
// ----------------------------------------------------------------------------
module gmti_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] rdata
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (int'(wr_ptr_q) == DEPTH - 1) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (int'(rd_ptr_q) == DEPTH - 1) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			cnt_q <= cnt_q + CNT_W'(do_push) - CNT_W'(do_pop);
		end
	end

endmodule

// ----- design/gmti_back.sv -----
// ----------------------------------------------------------------------------
// gmti_back
// Expands each queued vertex into its triangles or end marker and drives
// the registered result channel.
// ----------------------------------------------------------------------------
module gmti_back #(
	parameter int INDEX_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             empty,
	input  gmti_pkg::ctl_t                   ctl,
	input  logic [gmti_pkg::COUNT_W-1:0]     count,
	input  logic [INDEX_BITS-1:0]            yi,
	input  logic [INDEX_BITS-1:0]            stride,
	output logic                             pop,
	gmti_result_if.source                    res
);
	import gmti_pkg::*;

	logic                  valid_q;
	logic                  sel_q;
	logic [INDEX_BITS-1:0] first_q;
	logic [INDEX_BITS-1:0] second_q;
	logic [INDEX_BITS-1:0] third_q;
	logic                  present_q;
	logic                  last_q;
	logic                  done_q;
	logic [COUNT_W-1:0]    count_q;

	logic                  load;
	logic                  last;
	logic [INDEX_BITS-1:0] y1;
	logic [INDEX_BITS-1:0] x0;
	logic [INDEX_BITS-1:0] x1;

	assign load = !empty && (!valid_q || res.ready);
	assign last = sel_q || !(ctl.tri_a && ctl.tri_b);
	assign pop  = load && last;

	assign y1 = yi + INDEX_BITS'(1);
	assign x0 = yi + stride;
	assign x1 = x0 + INDEX_BITS'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sel_q   <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				sel_q   <= !last;
			end else if (res.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			last_q  <= last;
			done_q  <= ctl.done && last;
			count_q <= (ctl.done && last) ? count : '0;
			priority if (!sel_q && ctl.tri_a) begin
				first_q   <= yi;
				second_q  <= y1;
				third_q   <= ctl.diag_clk ? x0 : x1;
				present_q <= 1'b1;
			end else if (sel_q || ctl.tri_b) begin
				first_q   <= x1;
				second_q  <= x0;
				third_q   <= ctl.diag_clk ? y1 : yi;
				present_q <= 1'b1;
			end else begin
				first_q   <= '0;
				second_q  <= '0;
				third_q   <= '0;
				present_q <= ctl.end_present;
			end
		end
	end

	assign res.valid            = valid_q;
	assign res.first_index      = first_q;
	assign res.second_index     = second_q;
	assign res.third_index      = third_q;
	assign res.triangle_present = present_q;
	assign res.run_last         = last_q;
	assign res.grid_done        = done_q;
	assign res.index_count      = count_q;

endmodule

// ----- design/grid_mesh_triangle_indexer_core.sv -----
// ----------------------------------------------------------------------------
// grid_mesh_triangle_indexer_core
// Turns a streamed heightmap grid into the index list of its triangles.
// Vertices closing a triangle or ending the grid are queued; results leave
// from the output register. Throughput: 1 vertex per cycle while the queue
// is not full; 1 result per cycle out while res.ready is high, one per triangle.
// Reset: arst_n clears position, latches, total, queue and sets a 2x2 grid;
// the column validity line holds no reset value and needs no clearing.
// ----------------------------------------------------------------------------
module grid_mesh_triangle_indexer_core #(
	parameter int MAX_ROWS   = 255,
	parameter int INDEX_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [gmti_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [gmti_pkg::APB_DATA_W-1:0] pwdata,
	output logic [gmti_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready,
	gmti_vertex_if.sink                     vtx,
	gmti_result_if.source                   res
);
	import gmti_pkg::*;

	localparam int Q_W = $bits(ctl_t) + COUNT_W + 2 * INDEX_BITS;

	cfg_t                  cfg;
	logic                  push;
	logic                  pop;
	logic                  full;
	logic                  empty;
	ctl_t                  f_ctl;
	logic [COUNT_W-1:0]    f_count;
	logic [INDEX_BITS-1:0] f_yi;
	logic [INDEX_BITS-1:0] f_stride;
	ctl_t                  b_ctl;
	logic [COUNT_W-1:0]    b_count;
	logic [INDEX_BITS-1:0] b_yi;
	logic [INDEX_BITS-1:0] b_stride;
	logic [Q_W-1:0]        q_wdata;
	logic [Q_W-1:0]        q_rdata;

	assign q_wdata = {f_ctl, f_count, f_yi, f_stride};
	assign {b_ctl, b_count, b_yi, b_stride} = q_rdata;

	gmti_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	gmti_front #(
		.MAX_ROWS   (MAX_ROWS),
		.INDEX_BITS (INDEX_BITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.vtx    (vtx),
		.full   (full),
		.push   (push),
		.ctl    (f_ctl),
		.count  (f_count),
		.yi     (f_yi),
		.stride (f_stride)
	);

	gmti_fifo #(
		.WIDTH (Q_W),
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (q_wdata),
		.full   (full),
		.pop    (pop),
		.empty  (empty),
		.rdata  (q_rdata)
	);

	gmti_back #(
		.INDEX_BITS (INDEX_BITS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (empty),
		.ctl    (b_ctl),
		.count  (b_count),
		.yi     (b_yi),
		.stride (b_stride),
		.pop    (pop),
		.res    (res)
	);

endmodule
